FILE: src/bilinear_quad_shape_functions_core_assert.svh
// Assertion macros for the Q4 shape function core.
// Needs i_clk and i_rst_n in the scope of use.
`ifndef BILINEAR_QUAD_SHAPE_FUNCTIONS_CORE_ASSERT_SVH
`define BILINEAR_QUAD_SHAPE_FUNCTIONS_CORE_ASSERT_SVH
// same-cycle implication
`define Q4SF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define Q4SF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: src/q4sf_pkg.sv
// Shared types and constants for the Q4 shape function core.
// No dependencies.
package q4sf_pkg;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned NAT_W   = 18;
    localparam int unsigned JAC_W   = 33;
    localparam int unsigned GRAD_W  = 19;
    localparam int unsigned SHAPE_W = 17;
    localparam int unsigned DET_W   = 48;
    localparam int unsigned DM_W    = 49;
    localparam int unsigned DEN_W   = 51;
    localparam int unsigned NUM_W   = 52;
    localparam int unsigned QUO_W   = 32;
    localparam int unsigned IN_TDATA_W  = 296;
    localparam int unsigned OUT_TDATA_W = 136;
    localparam int unsigned OUT_TUSER_W = 4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NEG  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    // request token travelling with the data
    typedef struct packed {
        logic       valid;
        logic [1:0] node;
    } t_tok;

    // per-request payload carried past the divider
    typedef struct packed {
        logic [SHAPE_W-1:0] shape;
        logic [DET_W-1:0]   det;
        t_status            status;
    } t_side;

    // one restoring-division lane
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] q;
        logic             ovf;
        logic             neg;
    } t_lane;
endpackage

FILE: src/q4sf_jac.sv
// Front stages: clamp, node deltas, Jacobian entries, shape value, natural gradients.
// Depends on q4sf_pkg.
module q4sf_jac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  q4sf_pkg::t_tok                     i_tok,
    input  logic signed [q4sf_pkg::NAT_W-1:0]  i_xi,
    input  logic signed [q4sf_pkg::NAT_W-1:0]  i_eta,
    input  logic signed [q4sf_pkg::COORD_W-1:0] i_px [4],
    input  logic signed [q4sf_pkg::COORD_W-1:0] i_py [4],
    output q4sf_pkg::t_tok                     o_tok,
    output logic signed [q4sf_pkg::JAC_W-1:0]  o_j00,
    output logic signed [q4sf_pkg::JAC_W-1:0]  o_j01,
    output logic signed [q4sf_pkg::JAC_W-1:0]  o_j10,
    output logic signed [q4sf_pkg::JAC_W-1:0]  o_j11,
    output logic signed [q4sf_pkg::GRAD_W-1:0] o_gx,
    output logic signed [q4sf_pkg::GRAD_W-1:0] o_ge,
    output logic [q4sf_pkg::SHAPE_W-1:0]       o_shape
);
    import q4sf_pkg::*;

    // round to nearest, ties away from zero, drop 18 bits
    function automatic logic signed [JAC_W-1:0] rnd18(input logic signed [52:0] v);
        logic [52:0] mag;
        logic [52:0] m;
        mag = v[52] ? 53'(-v) : 53'(v);
        m   = (mag + 53'd131072) >> 18;
        return v[52] ? JAC_W'(-m) : JAC_W'(m);
    endfunction

    // stage 1
    t_tok r_t1;
    logic [NAT_W-1:0] r_a, r_b, r_c, r_d;
    logic signed [JAC_W-1:0] r_dx10, r_dx23, r_dx30, r_dx21;
    logic signed [JAC_W-1:0] r_dy10, r_dy23, r_dy30, r_dy21;
    logic signed [NAT_W-1:0] n_xc, n_ec;

    // stage 2
    t_tok r_t2;
    logic signed [51:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5, r_m6, r_m7;
    logic signed [GRAD_W-1:0] r_gx2, r_ge2;
    logic [35:0] r_sp;
    logic signed [GRAD_W-1:0] n_gx, n_ge;
    logic [35:0] n_sp;

    // stage 3
    t_tok r_t3;

    always_comb begin
        n_xc = (i_xi > 18'sd65536) ? 18'sd65536 : ((i_xi < -18'sd65536) ? -18'sd65536 : i_xi);
        n_ec = (i_eta > 18'sd65536) ? 18'sd65536 :
               ((i_eta < -18'sd65536) ? -18'sd65536 : i_eta);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= NAT_W'(19'sh10000 - {n_xc[17], n_xc});
            r_b <= NAT_W'(19'sh10000 + {n_xc[17], n_xc});
            r_c <= NAT_W'(19'sh10000 - {n_ec[17], n_ec});
            r_d <= NAT_W'(19'sh10000 + {n_ec[17], n_ec});
            r_dx10 <= {i_px[1][31], i_px[1]} - {i_px[0][31], i_px[0]};
            r_dx23 <= {i_px[2][31], i_px[2]} - {i_px[3][31], i_px[3]};
            r_dx30 <= {i_px[3][31], i_px[3]} - {i_px[0][31], i_px[0]};
            r_dx21 <= {i_px[2][31], i_px[2]} - {i_px[1][31], i_px[1]};
            r_dy10 <= {i_py[1][31], i_py[1]} - {i_py[0][31], i_py[0]};
            r_dy23 <= {i_py[2][31], i_py[2]} - {i_py[3][31], i_py[3]};
            r_dy30 <= {i_py[3][31], i_py[3]} - {i_py[0][31], i_py[0]};
            r_dy21 <= {i_py[2][31], i_py[2]} - {i_py[1][31], i_py[1]};
        end
    end

    always_comb begin
        unique case (r_t1.node)
            2'd0: begin
                n_gx = -$signed({1'b0, r_c});
                n_ge = -$signed({1'b0, r_a});
                n_sp = r_a * r_c;
            end
            2'd1: begin
                n_gx = $signed({1'b0, r_c});
                n_ge = -$signed({1'b0, r_b});
                n_sp = r_b * r_c;
            end
            2'd2: begin
                n_gx = $signed({1'b0, r_d});
                n_ge = $signed({1'b0, r_b});
                n_sp = r_b * r_d;
            end
            default: begin
                n_gx = -$signed({1'b0, r_d});
                n_ge = $signed({1'b0, r_a});
                n_sp = r_a * r_d;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0 <= $signed({1'b0, r_c}) * r_dx10;
            r_m1 <= $signed({1'b0, r_d}) * r_dx23;
            r_m2 <= $signed({1'b0, r_a}) * r_dx30;
            r_m3 <= $signed({1'b0, r_b}) * r_dx21;
            r_m4 <= $signed({1'b0, r_c}) * r_dy10;
            r_m5 <= $signed({1'b0, r_d}) * r_dy23;
            r_m6 <= $signed({1'b0, r_a}) * r_dy30;
            r_m7 <= $signed({1'b0, r_b}) * r_dy21;
            r_gx2 <= n_gx;
            r_ge2 <= n_ge;
            r_sp  <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_j00 <= rnd18({r_m0[51], r_m0} + {r_m1[51], r_m1});
            o_j01 <= rnd18({r_m2[51], r_m2} + {r_m3[51], r_m3});
            o_j10 <= rnd18({r_m4[51], r_m4} + {r_m5[51], r_m5});
            o_j11 <= rnd18({r_m6[51], r_m6} + {r_m7[51], r_m7});
            o_gx  <= r_gx2;
            o_ge  <= r_ge2;
            o_shape <= SHAPE_W'((r_sp + 36'd131072) >> 18);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
        end else if (i_en) begin
            r_t1 <= i_tok;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
        end
    end

    assign o_tok = r_t3;
endmodule

FILE: src/q4sf_det.sv
// Determinant, status and derivative numerators, prepared for division.
// Depends on q4sf_pkg.
module q4sf_det (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  q4sf_pkg::t_tok                     i_tok,
    input  logic signed [q4sf_pkg::JAC_W-1:0]  i_j00,
    input  logic signed [q4sf_pkg::JAC_W-1:0]  i_j01,
    input  logic signed [q4sf_pkg::JAC_W-1:0]  i_j10,
    input  logic signed [q4sf_pkg::JAC_W-1:0]  i_j11,
    input  logic signed [q4sf_pkg::GRAD_W-1:0] i_gx,
    input  logic signed [q4sf_pkg::GRAD_W-1:0] i_ge,
    input  logic [q4sf_pkg::SHAPE_W-1:0]       i_shape,
    output q4sf_pkg::t_tok                     o_tok,
    output q4sf_pkg::t_side                    o_side,
    output logic [q4sf_pkg::DEN_W-1:0]         o_den,
    output logic [q4sf_pkg::NUM_W-1:0]         o_nx,
    output logic                               o_sx,
    output logic [q4sf_pkg::NUM_W-1:0]         o_ny,
    output logic                               o_sy
);
    import q4sf_pkg::*;

    t_tok r_t4, r_t5, r_t6;
    logic signed [65:0] r_p, r_q;
    logic signed [51:0] r_ax, r_bx, r_ay, r_by;
    logic [SHAPE_W-1:0] r_sh4, r_sh5;
    logic [DM_W-1:0] r_dm;
    logic r_dneg;
    logic signed [52:0] r_nx, r_ny;
    logic signed [66:0] n_diff;
    logic [65:0] n_mag;
    logic [52:0] n_anx, n_any;
    t_status n_st;
    logic [DET_W-1:0] n_det;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= i_j00 * i_j11;
            r_q  <= i_j01 * i_j10;
            r_ax <= i_gx * i_j11;
            r_bx <= i_ge * i_j10;
            r_ay <= i_ge * i_j00;
            r_by <= i_gx * i_j01;
            r_sh4 <= i_shape;
        end
    end

    always_comb begin
        n_diff = {r_p[65], r_p} - {r_q[65], r_q};
        n_mag  = n_diff[66] ? 66'(-n_diff) : 66'(n_diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dm   <= DM_W'((n_mag + 66'd32768) >> 16);
            r_dneg <= n_diff[66];
            r_nx   <= {r_ax[51], r_ax} - {r_bx[51], r_bx};
            r_ny   <= {r_ay[51], r_ay} - {r_by[51], r_by};
            r_sh5  <= r_sh4;
        end
    end

    always_comb begin
        if (r_dm == '0)  n_st = ST_ZERO;
        else if (r_dneg) n_st = ST_NEG;
        else             n_st = ST_OK;
        if (!r_dneg)
            n_det = (r_dm > 49'h0_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : r_dm[DET_W-1:0];
        else
            n_det = (r_dm > 49'h0_8000_0000_0000) ? 48'h8000_0000_0000
                                                  : DET_W'(-{1'b0, r_dm});
        n_anx = r_nx[52] ? 53'(-r_nx) : 53'(r_nx);
        n_any = r_ny[52] ? 53'(-r_ny) : 53'(r_ny);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side.shape  <= r_sh5;
            o_side.det    <= n_det;
            o_side.status <= n_st;
            o_den <= {r_dm, 2'b00};
            o_nx  <= NUM_W'(n_anx + {3'b000, r_dm, 1'b0});
            o_ny  <= NUM_W'(n_any + {3'b000, r_dm, 1'b0});
            o_sx  <= r_nx[52];
            o_sy  <= r_ny[52];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t4 <= '0;
            r_t5 <= '0;
            r_t6 <= '0;
        end else if (i_en) begin
            r_t4 <= i_tok;
            r_t5 <= r_t4;
            r_t6 <= r_t5;
        end
    end

    assign o_tok = r_t6;
endmodule

FILE: src/q4sf_div.sv
// Two-lane pipelined restoring divider: an init stage, then one quotient bit per stage.
// Depends on q4sf_pkg.
module q4sf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  q4sf_pkg::t_tok             i_tok,
    input  q4sf_pkg::t_side            i_side,
    input  logic [q4sf_pkg::DEN_W-1:0] i_den,
    input  logic [q4sf_pkg::NUM_W-1:0] i_nx,
    input  logic                       i_sx,
    input  logic [q4sf_pkg::NUM_W-1:0] i_ny,
    input  logic                       i_sy,
    output q4sf_pkg::t_tok             o_tok,
    output q4sf_pkg::t_side            o_side,
    output q4sf_pkg::t_lane            o_x,
    output q4sf_pkg::t_lane            o_y
);
    import q4sf_pkg::*;

    localparam int unsigned NST = QUO_W + 1;

    function automatic t_lane div_step(input t_lane l, input logic [DEN_W-1:0] d);
        logic [DEN_W:0] t;
        t_lane r;
        t = {l.rem, l.low[QUO_W-1]};
        r = l;
        if (t >= {1'b0, d}) begin
            r.rem = DEN_W'(t - {1'b0, d});
            r.q   = {l.q[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = t[DEN_W-1:0];
            r.q   = {l.q[QUO_W-2:0], 1'b0};
        end
        r.low = {l.low[QUO_W-2:0], 1'b0};
        return r;
    endfunction

    function automatic t_lane div_init(input logic [NUM_W-1:0] n, input logic s,
                                       input logic [DEN_W-1:0] d);
        t_lane r;
        r.rem = {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, n[NUM_W-1:QUO_W]};
        r.low = n[QUO_W-1:0];
        r.q   = '0;
        r.ovf = (r.rem >= d);
        r.neg = s;
        return r;
    endfunction

    t_tok             r_tok  [NST];
    t_side            r_side [NST];
    logic [DEN_W-1:0] r_den  [NST];
    t_lane            r_lx   [NST];
    t_lane            r_ly   [NST];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            r_lx[0]   <= div_init(i_nx, i_sx, i_den);
            r_ly[0]   <= div_init(i_ny, i_sy, i_den);
        end
    end

    for (genvar s = 1; s < NST; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= r_side[s-1];
                r_den[s]  <= r_den[s-1];
                r_lx[s]   <= div_step(r_lx[s-1], r_den[s-1]);
                r_ly[s]   <= div_step(r_ly[s-1], r_den[s-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_tok[k] <= '0;
        end else if (i_en) begin
            r_tok[0] <= i_tok;
            for (int k = 1; k < NST; k++) r_tok[k] <= r_tok[k-1];
        end
    end

    assign o_tok  = r_tok[NST-1];
    assign o_side = r_side[NST-1];
    assign o_x    = r_lx[NST-1];
    assign o_y    = r_ly[NST-1];
endmodule

FILE: src/bilinear_quad_shape_functions_core.sv
// Q4 shape function core: one request in, four node results out, last one flagged.
// Results pass serializer, jac, det, divider and output register; node 0 first, then 1..3.
// New request taken only as node 3 of the last issues; one result per cycle unless stalled.
// The 33-stage restoring divider (init stage, then one quotient bit per stage) sets the depth.
// Reset: synchronous, active low; clears the serializer and all pipeline valid bits.
`include "bilinear_quad_shape_functions_core_assert.svh"
// Depends on q4sf_pkg, q4sf_jac, q4sf_det, q4sf_div.
module bilinear_quad_shape_functions_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // xi[17:0] eta[35:18] node0_x node0_y node1_x node1_y node2_x node2_y node3_x node3_y
    // (32 bits each from bit 36 up), zero pad [295:292]
    input  logic [q4sf_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // shape_value[16:0] deriv_x[48:17] deriv_y[80:49] jacobian_det[128:81], zero pad [135:129]
    output logic [q4sf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // node_index[1:0] status[3:2]
    output logic [q4sf_pkg::OUT_TUSER_W-1:0]    m_tuser,
    output logic                                m_tlast
);
    import q4sf_pkg::*;

    // One global advance: every stage moves when the output register can take data.
    logic en;
    logic s_acc;

    // Serializer: holds the accepted request and issues nodes 0..3 into the pipeline.
    logic r_hv;
    logic [1:0] r_node;
    logic signed [NAT_W-1:0] r_xi, r_eta;
    logic signed [COORD_W-1:0] r_px [4];
    logic signed [COORD_W-1:0] r_py [4];
    t_tok n_tok0;

    // Output register
    logic r_out_valid;
    logic [1:0] r_out_node;
    t_side r_out_side;
    logic signed [QUO_W-1:0] r_dx, r_dy;

    // inter-module wires
    t_tok jac_tok, det_tok, div_tok;
    logic signed [JAC_W-1:0] j00, j01, j10, j11;
    logic signed [GRAD_W-1:0] gx, ge;
    logic [SHAPE_W-1:0] shape;
    t_side det_side, div_side;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] nx, ny;
    logic sx, sy;
    t_lane lx, ly;

    assign en       = !r_out_valid || m_tready;
    assign s_tready = en && (!r_hv || (r_node == 2'd3));
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= 1'b0;
            r_node <= 2'd0;
        end else if (en) begin
            if (s_acc) begin
                r_hv   <= 1'b1;
                r_node <= 2'd0;
            end else if (r_hv) begin
                if (r_node == 2'd3) r_hv <= 1'b0;
                r_node <= r_node + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_xi  <= s_tdata[17:0];
            r_eta <= s_tdata[35:18];
            for (int k = 0; k < 4; k++) begin
                r_px[k] <= s_tdata[36 + 64*k +: 32];
                r_py[k] <= s_tdata[68 + 64*k +: 32];
            end
        end
    end

    assign n_tok0.valid = r_hv;
    assign n_tok0.node  = r_node;

    q4sf_jac u_jac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tok   (n_tok0),
        .i_xi    (r_xi),
        .i_eta   (r_eta),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_tok   (jac_tok),
        .o_j00   (j00),
        .o_j01   (j01),
        .o_j10   (j10),
        .o_j11   (j11),
        .o_gx    (gx),
        .o_ge    (ge),
        .o_shape (shape)
    );

    q4sf_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tok   (jac_tok),
        .i_j00   (j00),
        .i_j01   (j01),
        .i_j10   (j10),
        .i_j11   (j11),
        .i_gx    (gx),
        .i_ge    (ge),
        .i_shape (shape),
        .o_tok   (det_tok),
        .o_side  (det_side),
        .o_den   (den),
        .o_nx    (nx),
        .o_sx    (sx),
        .o_ny    (ny),
        .o_sy    (sy)
    );

    q4sf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tok   (det_tok),
        .i_side  (det_side),
        .i_den   (den),
        .i_nx    (nx),
        .i_sx    (sx),
        .i_ny    (ny),
        .i_sy    (sy),
        .o_tok   (div_tok),
        .o_side  (div_side),
        .o_x     (lx),
        .o_y     (ly)
    );

    // Saturate the rounded quotient to Q16.16; negative side reaches -2^31.
    function automatic logic signed [QUO_W-1:0] sat_q(input t_lane l);
        logic signed [QUO_W-1:0] r;
        if (l.neg) begin
            if (l.ovf || (l.q > 32'h8000_0000)) r = 32'sh8000_0000;
            else                                r = QUO_W'(-l.q);
        end else begin
            if (l.ovf || l.q[QUO_W-1]) r = 32'sh7FFF_FFFF;
            else                       r = l.q;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_node <= div_tok.node;
            r_out_side <= div_side;
            // bad or degenerate Jacobian: derivatives forced to zero
            r_dx <= (div_side.status == ST_OK) ? sat_q(lx) : '0;
            r_dy <= (div_side.status == ST_OK) ? sat_q(ly) : '0;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_out_side.det, r_dy, r_dx, r_out_side.shape};
    assign m_tuser  = {r_out_side.status, r_out_node};
    assign m_tlast  = (r_out_node == 2'd3);

    `Q4SF_ASSERT_NXT(a_acc_starts_node0, s_acc && en, r_hv && (r_node == 2'd0), "accepted request did not start at node 0")
    `Q4SF_ASSERT_NXT(a_node_steps, en && r_hv && (r_node != 2'd3) && !s_tvalid, r_hv && (r_node == 2'($past(r_node) + 2'd1)), "serializer skipped or repeated a node")
    `Q4SF_ASSERT_IMP(a_bad_det_zero_deriv, r_out_valid && (r_out_side.status != ST_OK), (r_dx == '0) && (r_dy == '0), "derivatives not zeroed on bad determinant")
    `Q4SF_ASSERT_IMP(a_zero_status_det, r_out_valid, (r_out_side.status == ST_ZERO) == (r_out_side.det == '0), "zero status and zero determinant disagree")
endmodule
